/* hdl/mf_pkg.sv */
// Shared types and constants for the 3x3 median filter.
package mf_pkg;

    // Pixel and window types
    typedef logic [7:0] pixel_t;
    typedef logic [8:0][7:0] window_t;

    // Configuration register fields
    localparam int IMG_WIDTH_W  = 11;
    localparam int IMG_HEIGHT_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RESET  = IMG_WIDTH_W'(640);
    localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RESET = IMG_HEIGHT_W'(480);

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

    // Queue depths: window queue between front and back, and result queue
    localparam int Q_DEPTH   = 4;
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

endpackage

/* hdl/mf_fifo.sv */
// Small synchronous queue with an occupancy count.
module mf_fifo
    import mf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic [CNT_W-1:0] count
);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Pointer wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = data_reg[rd_ptr_reg];
    assign count   = count_reg;

    // Credit logic upstream must never overfill or over-drain the queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && count_reg == CNT_W'(DEPTH)))
        else $error("word pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && count_reg == '0))
        else $error("word popped from an empty queue");

endmodule

/* hdl/mf_front.sv */
// Front end: position counters, line stores, window register and result classification.
module mf_front
    import mf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int ROW_W = $clog2(MAX_HEIGHT)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [IMG_WIDTH_W-1:0]  image_width,
    input  logic [IMG_HEIGHT_W-1:0] image_height,
    input  logic                    push,
    input  pixel_t                  pixel,
    output logic                    full,
    input  logic [Q_CNT_W-1:0]      q_count,
    output logic                    q_push,
    output window_t                 q_window,
    output logic [COL_W-1:0]        q_col,
    output logic [ROW_W-1:0]        q_row,
    output logic                    q_last
);

    localparam int WE_W = COL_W + 1;
    localparam int HE_W = ROW_W + 1;

    // Line stores, one entry per column
    pixel_t upper_line_reg  [MAX_WIDTH];
    pixel_t middle_line_reg [MAX_WIDTH];
    pixel_t up_rd_reg, mid_rd_reg;

    logic [COL_W-1:0] col_count_reg, col_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;

    // Second stage
    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    logic             s1_fwd_reg;
    pixel_t           s1_px_reg;
    pixel_t           s1_fwd_up_reg;
    pixel_t           s1_fwd_mid_reg;
    logic [COL_W-1:0] s1_idx_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;

    window_t window_reg, window_next;

    logic [WE_W-1:0] w_eff;
    logic [HE_W-1:0] h_eff;
    logic [WE_W-1:0] col_ext, col_inc;
    logic [HE_W-1:0] row_ext, row_inc;
    logic            col_wrap, row_wrap;
    logic            emit0, last0;
    logic            accept;
    pixel_t          up_eff, mid_eff;

    // Frame size, zero read as one and large values saturated
    assign w_eff = (image_width == '0) ? WE_W'(1) :
                   (32'(image_width) > 32'(MAX_WIDTH)) ? WE_W'(MAX_WIDTH) : WE_W'(image_width);
    assign h_eff = (image_height == '0) ? HE_W'(1) :
                   (32'(image_height) > 32'(MAX_HEIGHT)) ? HE_W'(MAX_HEIGHT) : HE_W'(image_height);

    // One word in flight in the second stage, so reserve a slot for it
    assign full   = (Q_CNT_W + 1)'(q_count) + (Q_CNT_W + 1)'(s1_valid_reg)
                    >= (Q_CNT_W + 1)'(Q_DEPTH);
    assign accept = push && !full;

    // Position classification
    assign col_ext  = {1'b0, col_count_reg};
    assign row_ext  = {1'b0, row_count_reg};
    assign col_inc  = col_ext + 1'b1;
    assign row_inc  = row_ext + 1'b1;
    assign col_wrap = col_inc >= w_eff;
    assign row_wrap = row_inc >= h_eff;
    assign emit0    = (col_ext >= WE_W'(2)) && (row_ext >= HE_W'(2)) &&
                      (col_ext < w_eff) && (row_ext < h_eff);
    assign last0    = (col_inc == w_eff) && (row_inc == h_eff);

    always_comb
    begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_count_next = '0;
                row_count_next = row_wrap ? '0 : row_count_reg + 1'b1;
            end
            else
            begin
                col_count_next = col_count_reg + 1'b1;
            end
        end
    end

    // Line store read data, with bypass when the previous word hits the same column
    assign up_eff  = s1_fwd_reg ? s1_fwd_up_reg  : up_rd_reg;
    assign mid_eff = s1_fwd_reg ? s1_fwd_mid_reg : mid_rd_reg;

    // Window shift: oldest column drops out, new column enters on the right
    always_comb
    begin
        window_next = window_reg;
        if (s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                window_next[3 * r]     = window_reg[3 * r + 1];
                window_next[3 * r + 1] = window_reg[3 * r + 2];
            end
            window_next[2] = up_eff;
            window_next[5] = mid_eff;
            window_next[8] = s1_px_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s1_emit_reg   <= 1'b0;
            s1_fwd_reg    <= 1'b0;
            window_reg    <= '0;
        end
        else
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            s1_valid_reg  <= accept;
            window_reg    <= window_next;
            if (accept)
            begin
                s1_emit_reg <= emit0;
                s1_fwd_reg  <= s1_valid_reg && (s1_idx_reg == col_count_reg);
            end
        end
    end

    // Second stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg      <= pixel;
            s1_idx_reg     <= col_count_reg;
            s1_col_reg     <= col_count_reg - 1'b1;
            s1_row_reg     <= row_count_reg - 1'b1;
            s1_last_reg    <= last0;
            s1_fwd_up_reg  <= mid_eff;
            s1_fwd_mid_reg <= s1_px_reg;
        end
    end

    // Line stores: read on accept, written back in the following cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd_reg  <= upper_line_reg[col_count_reg];
            mid_rd_reg <= middle_line_reg[col_count_reg];
        end
        if (s1_valid_reg)
        begin
            upper_line_reg[s1_idx_reg]  <= mid_eff;
            middle_line_reg[s1_idx_reg] <= s1_px_reg;
        end
    end

    assign q_push   = s1_valid_reg && s1_emit_reg;
    assign q_window = window_next;
    assign q_col    = s1_col_reg;
    assign q_row    = s1_row_reg;
    assign q_last   = s1_last_reg;

    // Last pixel of the frame sends both counters back to the origin
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && col_wrap && row_wrap) |=> (col_count_reg == '0 && row_count_reg == '0))
        else $error("position counters did not wrap at frame end");

    // A result centre never lies on the top row or left column
    a_centre_inside: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_col != '0 && q_row != '0))
        else $error("result centre on the frame border");

endmodule

/* hdl/mf_median.sv */
// Back end: three-stage median network from the window queue to the result queue.
module mf_median
    import mf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int ROW_W = $clog2(MAX_HEIGHT)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  window_t              q_window,
    input  logic [COL_W-1:0]     q_col,
    input  logic [ROW_W-1:0]     q_row,
    input  logic                 q_last,
    output logic                 q_pop,
    input  logic [OUT_CNT_W-1:0] out_count,
    output logic                 out_push,
    output pixel_t               out_median,
    output logic [COL_W-1:0]     out_col,
    output logic [ROW_W-1:0]     out_row,
    output logic                 out_last
);

    typedef struct packed {
        pixel_t hi;
        pixel_t mi;
        pixel_t lo;
    } trio_t;

    function automatic pixel_t min2(pixel_t a, pixel_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pixel_t max2(pixel_t a, pixel_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pixel_t med3(pixel_t a, pixel_t b, pixel_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic trio_t sort3(pixel_t a, pixel_t b, pixel_t c);
        trio_t t;
        t.lo = min2(min2(a, b), c);
        t.hi = max2(max2(a, b), c);
        t.mi = med3(a, b, c);
        return t;
    endfunction

    trio_t            a_row_reg [3];
    logic             a_valid_reg, b_valid_reg;
    logic [COL_W-1:0] a_col_reg, b_col_reg;
    logic [ROW_W-1:0] a_row_pos_reg, b_row_pos_reg;
    logic             a_last_reg, b_last_reg;
    pixel_t           b_lo_reg, b_mi_reg, b_hi_reg;

    // Issue only when the result queue has room for everything in flight
    assign q_pop = !q_empty &&
                   ((OUT_CNT_W + 1)'(out_count) + (OUT_CNT_W + 1)'(a_valid_reg) +
                    (OUT_CNT_W + 1)'(b_valid_reg) < (OUT_CNT_W + 1)'(OUT_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= q_pop;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Stage A: sort each window row
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            a_row_reg[r] <= sort3(q_window[3 * r], q_window[3 * r + 1], q_window[3 * r + 2]);
        end
        a_col_reg     <= q_col;
        a_row_pos_reg <= q_row;
        a_last_reg    <= q_last;
    end

    // Stage B: largest low, middle of middles, smallest high
    always_ff @(posedge clk)
    begin
        b_lo_reg      <= max2(max2(a_row_reg[0].lo, a_row_reg[1].lo), a_row_reg[2].lo);
        b_mi_reg      <= med3(a_row_reg[0].mi, a_row_reg[1].mi, a_row_reg[2].mi);
        b_hi_reg      <= min2(min2(a_row_reg[0].hi, a_row_reg[1].hi), a_row_reg[2].hi);
        b_col_reg     <= a_col_reg;
        b_row_pos_reg <= a_row_pos_reg;
        b_last_reg    <= a_last_reg;
    end

    // Stage C: median of the three, registered in the result queue
    assign out_push   = b_valid_reg;
    assign out_median = med3(b_lo_reg, b_mi_reg, b_hi_reg);
    assign out_col    = b_col_reg;
    assign out_row    = b_row_pos_reg;
    assign out_last   = b_last_reg;

endmodule

/* hdl/median_filter_3x3_unit.sv */
// Top level of the streaming 3x3 median filter.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------------
//  pixels in | push / full          | pixel
//  results   | pop / empty          | median, center_column, center_row, frame_last
//  config    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One pixel word is taken per clock while nothing stalls; each line store takes the
//  read for a new word and the write-back of the previous word in the same cycle,
//  with a bypass when back-to-back words fall on one column.
//  Between the edge that accepts its pixel and the result ports, a median passes through
//  line store read, window shift into the window queue, row sort, merge stage.
//  Reset sets width 640 and height 480 and zeroes counters and window; line stores
//  are not cleared, as their stale entries never reach a result.
//  full rises when the window queue, counting the word in the second front stage,
//  has no free slot; the median stages stop issuing when the result queue cannot
//  take all words in flight.
module median_filter_3x3_unit
    import mf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    localparam int COL_W = $clog2(MAX_WIDTH),
    localparam int ROW_W = $clog2(MAX_HEIGHT)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  pixel_t                 pixel,
    output logic                   empty,
    input  logic                   pop,
    output pixel_t                 median,
    output logic [COL_W-1:0]       center_column,
    output logic [ROW_W-1:0]       center_row,
    output logic                   frame_last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int Q_W   = $bits(window_t) + COL_W + ROW_W + 1;
    localparam int OUT_W = $bits(pixel_t) + COL_W + ROW_W + 1;

    logic [IMG_WIDTH_W-1:0]  image_width_reg;
    logic [IMG_HEIGHT_W-1:0] image_height_reg;

    logic                 q_push, q_pop;
    window_t              q_window_in, q_window_out;
    logic [COL_W-1:0]     q_col_in, q_col_out;
    logic [ROW_W-1:0]     q_row_in, q_row_out;
    logic                 q_last_in, q_last_out;
    logic [Q_CNT_W-1:0]   q_count;

    logic                 out_push, out_pop;
    pixel_t               out_median;
    logic [COL_W-1:0]     out_col;
    logic [ROW_W-1:0]     out_row;
    logic                 out_last;
    logic [OUT_CNT_W-1:0] out_count;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= IMG_WIDTH_RESET;
            image_height_reg <= IMG_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[IMG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[IMG_HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Front end
    mf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .push         (push),
        .pixel        (pixel),
        .full         (full),
        .q_count      (q_count),
        .q_push       (q_push),
        .q_window     (q_window_in),
        .q_col        (q_col_in),
        .q_row        (q_row_in),
        .q_last       (q_last_in)
    );

    // Window queue between front and back
    mf_fifo #(
        .WIDTH (Q_W),
        .DEPTH (Q_DEPTH)
    ) u_win_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data ({q_window_in, q_col_in, q_row_in, q_last_in}),
        .pop     (q_pop),
        .rd_data ({q_window_out, q_col_out, q_row_out, q_last_out}),
        .count   (q_count)
    );

    // Back end
    mf_median #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_median (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_count == '0),
        .q_window   (q_window_out),
        .q_col      (q_col_out),
        .q_row      (q_row_out),
        .q_last     (q_last_out),
        .q_pop      (q_pop),
        .out_count  (out_count),
        .out_push   (out_push),
        .out_median (out_median),
        .out_col    (out_col),
        .out_row    (out_row),
        .out_last   (out_last)
    );

    // Result queue
    assign empty   = (out_count == '0);
    assign out_pop = pop && !empty;

    mf_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .wr_data ({out_median, out_col, out_row, out_last}),
        .pop     (out_pop),
        .rd_data ({median, center_column, center_row, frame_last}),
        .count   (out_count)
    );

endmodule

/* tb/median_filter_3x3_checker.sv */
// Scoreboard for the 3x3 median filter: predicts median words from accepted pixels.
`timescale 1ns / 1ps
module median_filter_3x3_checker
    import mf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int COL_W      = 10,
    parameter int ROW_W      = 12
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   full,
    input  pixel_t                 pixel,
    input  logic                   empty,
    input  logic                   pop,
    input  pixel_t                 median,
    input  logic [COL_W-1:0]       center_column,
    input  logic [ROW_W-1:0]       center_row,
    input  logic                   frame_last,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     pending_medians,
    output int                     mismatches
);

    localparam logic [IMG_WIDTH_W-1:0]  WIDTH_AFTER_RESET  = IMG_WIDTH_W'(640);
    localparam logic [IMG_HEIGHT_W-1:0] HEIGHT_AFTER_RESET = IMG_HEIGHT_W'(480);
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        pixel_t           median;
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
        logic             last;
    } median_word_t;

    median_word_t expected_medians[$];
    median_word_t want;

    // Predictor state: register copies, two previous rows, window, position
    logic [IMG_WIDTH_W-1:0]  width_reg;
    logic [IMG_HEIGHT_W-1:0] height_reg;
    pixel_t                  upper_row [MAX_WIDTH];
    pixel_t                  middle_row [MAX_WIDTH];
    logic [8:0][7:0]         window;
    int unsigned             col_pos;
    int unsigned             row_pos;
    int unsigned             eff_width;
    int unsigned             eff_height;
    int unsigned             slot;
    pixel_t                  up_px;
    pixel_t                  mid_px;

    // Zero counts as one, anything above the store size saturates
    function automatic int unsigned frame_size(input int unsigned v, input int unsigned limit);
        if (v == 0)
            return 1;
        return (v > limit) ? limit : v;
    endfunction

    // Fifth smallest: the value with fewer than five below it and at least five not above it
    function automatic pixel_t fifth_smallest(input logic [8:0][7:0] nine);
        int     below;
        int     not_above;
        pixel_t v;
        fifth_smallest = '0;
        for (int i = 0; i < 9; i++)
        begin
            v         = nine[i];
            below     = 0;
            not_above = 0;
            for (int j = 0; j < 9; j++)
            begin
                if (nine[j] < v)
                    below++;
                if (nine[j] <= v)
                    not_above++;
            end
            if (below < 5 && not_above >= 5)
                fifth_smallest = v;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = WIDTH_AFTER_RESET;
            height_reg = HEIGHT_AFTER_RESET;
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            window          = '0;
            col_pos         = 0;
            row_pos         = 0;
            expected_medians.delete();
            pending_medians = 0;
            mismatches      = 0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    width_reg = cfg_data[IMG_WIDTH_W-1:0];
                else if (cfg_index == REG_IMAGE_HEIGHT)
                    height_reg = cfg_data[IMG_HEIGHT_W-1:0];
            end

            // result side: compare against the oldest expected word
            if (pop && !empty)
            begin
                if (expected_medians.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected median %0d at column %0d row %0d last %0b",
                                 $realtime, median, center_column, center_row, frame_last);
                end
                else
                begin
                    want = expected_medians.pop_front();
                    if (median !== want.median || center_column !== want.column ||
                        center_row !== want.row || frame_last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $write("%0t: median word mismatch: expected %0d/%0d/%0d/%0b, ",
                                   $realtime, want.median, want.column, want.row, want.last);
                            $display("got %0d/%0d/%0d/%0b (median/column/row/last)",
                                     median, center_column, center_row, frame_last);
                        end
                    end
                end
            end

            // pixel side: shift line stores and window, form a median off the border
            if (push && !full)
            begin
                eff_width  = frame_size(width_reg, MAX_WIDTH);
                eff_height = frame_size(height_reg, MAX_HEIGHT);
                slot       = col_pos % MAX_WIDTH;
                up_px      = upper_row[slot];
                mid_px     = middle_row[slot];
                upper_row[slot]  = mid_px;
                middle_row[slot] = pixel;
                for (int r = 0; r < 3; r++)
                begin
                    window[3*r]     = window[3*r + 1];
                    window[3*r + 1] = window[3*r + 2];
                end
                window[2] = up_px;
                window[5] = mid_px;
                window[8] = pixel;

                if (col_pos >= 2 && row_pos >= 2 && col_pos < eff_width && row_pos < eff_height)
                begin
                    want.median = fifth_smallest(window);
                    want.column = COL_W'(col_pos - 1);
                    want.row    = ROW_W'(row_pos - 1);
                    want.last   = (col_pos + 1 == eff_width) && (row_pos + 1 == eff_height);
                    expected_medians.push_back(want);
                end

                // wrap at end of row and frame
                if (col_pos + 1 >= eff_width)
                begin
                    col_pos = 0;
                    row_pos = (row_pos + 1 >= eff_height) ? 0 : row_pos + 1;
                end
                else
                    col_pos = col_pos + 1;
            end

            pending_medians = expected_medians.size();
        end
    end

endmodule

/* tb/tb_median_filter_3x3_unit.sv */
// Testbench top for the 3x3 median filter: clock, reset, pixel and register stimulus, verdict.
`timescale 1ns / 1ps
module tb_median_filter_3x3_unit
    import mf_pkg::*;
;

    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int COL_W         = 10;
    localparam int ROW_W         = 12;
    localparam int RESET_CYCLES  = 4;
    localparam int DRAIN_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_PIXELS = 560;
    localparam int HOLD_CYCLES   = 150;

    // Index with no register behind it
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = CFG_INDEX_W'(3);

    // Pixel content styles
    localparam int PIX_UNIFORM = 0;
    localparam int PIX_EXTREME = 1;
    localparam int PIX_BAND    = 2;

    // Hand-picked 3x3 frames, first pixel in the low byte
    localparam logic [2:0][71:0] SMALL_FRAMES = {
        {8'd255, 8'd7, 8'd0, 8'd7, 8'd0, 8'd7, 8'd0, 8'd7, 8'd0},
        {8'd4, 8'd3, 8'd5, 8'd2, 8'd6, 8'd1, 8'd7, 8'd0, 8'd8},
        {9{8'hFF}}
    };

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   push      = 1'b0;
    pixel_t                 pixel     = '0;
    logic                   pop       = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   full;
    logic                   empty;
    pixel_t                 median;
    logic [COL_W-1:0]       center_column;
    logic [ROW_W-1:0]       center_row;
    logic                   frame_last;
    logic                   cfg_ready;
    int                     pending_medians;
    int                     mismatches;

    int     tx_idle_pct   = 8;
    int     rx_idle_pct   = 59;
    int     hold_left     = 0;
    bit     hold_request  = 1'b0;
    int     cycle_count   = 0;
    int     random_pixels = 0;
    int     seg;
    int     roll;
    int     cols;
    int     rows;
    int     count;
    int     style;

    always #5 clk = ~clk;

    median_filter_3x3_unit dut (.*);

    median_filter_3x3_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W)
    ) checker_i (.*);

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_median_filter_3x3_unit NOT OK");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
            pop <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic pixel_t pick_pixel(input int kind);
        case (kind)
            PIX_EXTREME: return $urandom_range(1) ? 8'hFF : 8'h00;
            PIX_BAND:    return pixel_t'($urandom_range(120, 123));
            default:     return pixel_t'($urandom_range(255));
        endcase
    endfunction

    // Offer one pixel word, with random gaps, until taken
    task automatic send_pixel(input pixel_t value);
        bit taken;
        taken = 1'b0;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push  <= 1'b1;
        pixel <= value;
        while (!taken)
        begin
            @(posedge clk);
            taken = !full;
            @(negedge clk);
        end
    endtask

    // Stop sending, let every expected median drain, then let the pipeline settle
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_medians != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int value);
        bit taken;
        taken = 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_DATA_W'(value);
        while (!taken)
        begin
            @(posedge clk);
            taken = cfg_ready;
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_frame(input int width, input int height);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, width);
        write_reg(REG_IMAGE_HEIGHT, height);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset width 640: 639 pixels leave row 0 open at column 639, a width of 3
        // then wraps the next pixel to row 1, and cutting the height to 3 in row 2
        // makes the only median of the frame also its last
        repeat (640 - 1) send_pixel(pick_pixel(PIX_UNIFORM));
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 3);
        repeat (5) send_pixel(pick_pixel(PIX_UNIFORM));
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 3);
        repeat (2) send_pixel(pick_pixel(PIX_UNIFORM));

        // smallest full frame: saturated, ramp and tied windows
        set_frame(3, 3);
        for (int f = 0; f < 3; f++)
            for (int i = 0; i < 9; i++)
                send_pixel(SMALL_FRAMES[f][8*i +: 8]);

        // frames too small for any median, zero sizes, masked upper bits, spare index
        set_frame(1, 1);
        repeat (3) send_pixel(pick_pixel(PIX_UNIFORM));
        set_frame(0, 2);
        repeat (4) send_pixel(pick_pixel(PIX_UNIFORM));
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 'h1805);
        write_reg(REG_IMAGE_HEIGHT, 0);
        write_reg(REG_SPARE, 'h1FFF);
        repeat (10) send_pixel(pick_pixel(PIX_UNIFORM));

        // width shrunk mid-frame at the start of row 3
        set_frame(6, 6);
        repeat (18) send_pixel(pick_pixel(PIX_UNIFORM));
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 4);
        repeat (12) send_pixel(pick_pixel(PIX_UNIFORM));

        // random whole frames, idling pattern moves on by thirds
        seg = 0;
        while (random_pixels < RANDOM_PIXELS)
        begin
            if (random_pixels >= 2 * RANDOM_PIXELS / 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else if (random_pixels >= RANDOM_PIXELS / 3)
            begin
                tx_idle_pct = 59;
                rx_idle_pct = 8;
            end
            if (seg == 0)
            begin
                cols = 12;
                rows = 6;
            end
            else
            begin
                roll = $urandom_range(9);
                if (roll == 0)
                    cols = $urandom_range(1, 2);
                else if (roll == 1)
                    cols = $urandom_range(13, 40);
                else
                    cols = $urandom_range(3, 12);
                rows = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            end
            count = cols * rows * $urandom_range(1, 2);
            set_frame(cols, rows);
            // first frame: receiver holds off so the block fills and stalls its input
            if (seg == 0)
                hold_request = 1'b1;
            style = $urandom_range(2);
            repeat (count) send_pixel(pick_pixel(style));
            random_pixels += count;
            seg++;
        end

        // sizes above the store limits, then a small frame entered in the middle of row 0
        set_frame(2047, 8191);
        repeat (12) send_pixel(pick_pixel(PIX_UNIFORM));
        set_frame(7, 5);
        repeat (35) send_pixel(pick_pixel(PIX_BAND));

        wait_idle();
        if (mismatches == 0)
            $display("tb_median_filter_3x3_unit OK");
        else
            $display("tb_median_filter_3x3_unit NOT OK");
        $finish;
    end

endmodule
